FILE: rtl/core/emt_pkg.sv
// Shared types and constants for the encoder multi-turn tracker.
// No dependencies.
package emt_pkg;

	localparam int ANGLE_BITS    = 14;
	localparam int TURN_BITS     = 18;
	localparam int POS_BITS      = 32;
	localparam int AGE_BITS      = 16;
	localparam int CFG_DATA_BITS = 14;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_OFFSET = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REVERSE     = 1'd1;

	typedef struct packed {
		logic [POS_BITS-1:0]   position;
		logic [TURN_BITS-1:0]  turn_count;
		logic [ANGLE_BITS-1:0] angle;
		logic [AGE_BITS-1:0]   sample_age;
		logic                  read_error;
		logic                  feedback_valid;
	} emt_result_t;

endpackage

FILE: rtl/core/emt_skid.sv
// Two-entry output buffer for tracker results: output register plus skid slot.
// Depends on emt_pkg.
module emt_skid
	import emt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  emt_result_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output emt_result_t out_data
);

	emt_result_t main_q;
	emt_result_t skid_q;
	logic        main_valid_q;
	logic        skid_valid_q;
	logic        main_load;
	logic        skid_load;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	assign main_load = out_ready || !main_valid_q;
	assign skid_load = !main_load && in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_load) begin
			main_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (skid_load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_load) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end
		if (skid_load) begin
			skid_q <= in_data;
		end
	end

endmodule

FILE: rtl/core/encoder_multiturn_tracker_unit.sv
// Multi-turn tracker for a 14-bit absolute angle sensor: angle correction,
// turn counting, hold on failed reads and sample aging.
// Depends on emt_pkg and emt_skid.
// Accepted results go to the output register, or to the skid slot while the output stalls.
// Throughput: one request per cycle while the skid slot is empty; turn state updates at the accept edge, and
// a two-entry output buffer keeps input ready while one result is stalled.
// Reset: turns, baseline and valid flags cleared, sample age set to all ones,
// held angle and position zero, both configuration registers zero.
module encoder_multiturn_tracker_unit
	import emt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [23:0]              s_tdata,  // raw_high_byte, raw_low_byte, rebaseline, zero fill
	input  logic [0:0]               s_tuser,  // read_ok
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [79:0]              m_tdata,  // sample_age, angle, turn_count, position
	output logic [1:0]               m_tuser   // feedback_valid, read_error
);

	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	logic [ANGLE_BITS-1:0] zero_offset_q;
	logic                  reverse_q;
	logic [TURN_BITS-1:0]  turns_q;
	logic [ANGLE_BITS-1:0] prev_angle_q;
	logic                  baseline_q;
	logic [AGE_BITS-1:0]   age_q;
	logic                  ever_valid_q;
	logic [ANGLE_BITS-1:0] held_angle_q;
	logic [POS_BITS-1:0]   held_pos_q;

	logic                  s_acc;
	logic                  read_ok;
	logic                  rebaseline;
	logic [15:0]           raw_word;
	logic [ANGLE_BITS-1:0] raw_angle;
	logic [ANGLE_BITS-1:0] offs_angle;
	logic [ANGLE_BITS-1:0] ang;
	logic signed [ANGLE_BITS:0] diff;
	logic [TURN_BITS-1:0]  turns_n;
	logic [POS_BITS-1:0]   pos_n;
	logic [AGE_BITS-1:0]   age_n;
	emt_result_t           res;
	emt_result_t           out_res;

	assign s_acc      = s_tvalid && s_tready;
	assign read_ok    = s_tuser[0];
	assign rebaseline = s_tdata[16];
	assign raw_word   = {s_tdata[7:0], s_tdata[15:8]};
	assign raw_angle  = raw_word[15 -: ANGLE_BITS];

	always_comb begin
		offs_angle = raw_angle - zero_offset_q;
		ang = (reverse_q && offs_angle != '0) ? ANGLE_BITS'(-offs_angle) : offs_angle;
		diff = $signed({1'b0, ang}) - $signed({1'b0, prev_angle_q});

		turns_n = turns_q;
		if (rebaseline) begin
			turns_n = '0;
		end else if (baseline_q) begin
			// a large drop means the angle wrapped forward
			if (diff < -$signed((ANGLE_BITS+1)'(1 << (ANGLE_BITS-1)))) begin
				turns_n = turns_q + TURN_BITS'(1);
			end else if (diff > $signed((ANGLE_BITS+1)'(1 << (ANGLE_BITS-1)))) begin
				turns_n = turns_q - TURN_BITS'(1);
			end
		end

		pos_n = (POS_BITS'($signed(turns_n)) << ANGLE_BITS) + POS_BITS'(ang);
		age_n = (age_q == AGE_MAX) ? age_q : age_q + AGE_BITS'(1);

		res.feedback_valid = ever_valid_q || read_ok;
		res.read_error     = !read_ok;
		res.sample_age     = read_ok ? '0 : age_n;
		res.angle          = read_ok ? ang : held_angle_q;
		res.turn_count     = read_ok ? turns_n : turns_q;
		res.position       = read_ok ? pos_n : held_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			reverse_q     <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ZERO_OFFSET: zero_offset_q <= ANGLE_BITS'(cfg_wdata);
				REG_REVERSE:     reverse_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turns_q      <= '0;
			prev_angle_q <= '0;
			baseline_q   <= 1'b0;
			age_q        <= '1;
			ever_valid_q <= 1'b0;
			held_angle_q <= '0;
			held_pos_q   <= '0;
		end else if (s_acc) begin
			age_q <= res.sample_age;
			if (read_ok) begin
				turns_q      <= turns_n;
				prev_angle_q <= ang;
				baseline_q   <= 1'b1;
				ever_valid_q <= 1'b1;
				held_angle_q <= ang;
				held_pos_q   <= pos_n;
			end
		end
	end

	emt_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.position, out_res.turn_count, out_res.angle, out_res.sample_age};
	assign m_tuser = {out_res.read_error, out_res.feedback_valid};

	a_good_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && read_ok |=> age_q == '0)
		else $error("sample age not cleared after good read");

	a_fail_holds_turns: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !read_ok |=> $stable(turns_q) && $stable(held_pos_q))
		else $error("turn state changed on failed read");

	a_rebase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && read_ok && rebaseline |=> turns_q == '0 && held_pos_q == POS_BITS'(held_angle_q))
		else $error("rebaseline did not zero the turn count");

	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ever_valid_q |=> ever_valid_q && baseline_q)
		else $error("feedback valid dropped");

endmodule
